// ----- rtl/ats_pkg.sv -----
// Shared types, constants and helper functions of the assembler token scanner.
`timescale 1ns / 1ps

package ats_pkg;

  // Sizes that do not vary.
  localparam int LexemeBytes = 8;
  localparam int NumberBits  = 32;
  localparam int QueueDepth  = 4;

  // Only the first LexemeBytes bytes of the lexeme are reported.
  localparam logic [63:0] LexMask = {64{1'b1}} >> (64 - 8 * LexemeBytes);

  // Character codes the scanner reacts to.
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChUpperX = 8'h58;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLbrk   = 8'h5B;
  localparam logic [7:0] ChRbrk   = 8'h5D;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] ChLowerX = 8'h78;
  localparam logic [7:0] ChLowerZ = 8'h7A;

  // Register names, first character in the low byte.
  localparam logic [23:0] RegNames [8] = '{
    24'h786165, 24'h786265, 24'h786365, 24'h786465,
    24'h697365, 24'h696465, 24'h707365, 24'h706265
  };

  typedef enum logic [3:0] {
    TK_EOF      = 4'd0,
    TK_NEWLINE  = 4'd1,
    TK_IDENT    = 4'd2,
    TK_REGISTER = 4'd3,
    TK_NUMBER   = 4'd4,
    TK_STRING   = 4'd5,
    TK_COMMA    = 4'd6,
    TK_COLON    = 4'd7,
    TK_LBRACKET = 4'd8,
    TK_RBRACKET = 4'd9,
    TK_PLUS     = 4'd10,
    TK_MINUS    = 4'd11
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_ZERO    = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_DEC     = 3'd4,
    MODE_STRING  = 3'd5,
    MODE_COMMENT = 3'd6
  } mode_e;

  // One token as it leaves the block.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] num;
    logic [2:0]  reg_idx;
    logic [63:0] text;
    logic [5:0]  len;
    logic        trunc;
  } tok_t;

  // Everything one source byte produces: a token and possibly a second plain token.
  typedef struct packed {
    tok_t  first;
    logic  two;
    kind_e second;
  } rec_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Token without value or lexeme.
  function automatic tok_t make_simple(kind_e kind);
    tok_t t;
    t.kind    = kind;
    t.num     = '0;
    t.reg_idx = '0;
    t.text    = '0;
    t.len     = '0;
    t.trunc   = 1'b0;
    return t;
  endfunction

  // Register lookup on the first three lexeme bytes: {hit, index}.
  function automatic logic [3:0] reg_match(logic [23:0] lex);
    logic [3:0] res;
    res = '0;
    for (int r = 0; r < 8; r++) begin
      if (lex == RegNames[r]) begin
        res = {1'b1, 3'(r)};
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/ats_front.sv -----
// Front part: accepts source bytes, runs the scan modes and builds token records.
`timescale 1ns / 1ps

module ats_front import ats_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [7:0] in_char_i,
  input  q_status_t q_stat_i,
  output logic      push_o,
  output rec_t      rec_o
);

  mode_e                 mode_q, mode_d;
  logic [NumberBits-1:0] acc_q, acc_d;
  logic [63:0]           buf_q, buf_d;
  logic [5:0]            cnt_q, cnt_d;

  logic       fire;
  logic [7:0] c;
  logic       is_alpha, is_digit, is_idch, is_hex;
  logic [3:0] hex_d;
  logic [3:0] reg_hit;
  logic       end_v, run_idle, simp_v;
  tok_t       end_tok;
  kind_e      simp_kind;

  assign c          = in_char_i;
  assign in_ready_o = !q_stat_i.full;
  assign fire       = in_valid_i && in_ready_o;

  // Character classes.
  always_comb begin
    is_alpha = ((c >= ChLowerA) && (c <= ChLowerZ)) || ((c >= ChUpperA) && (c <= ChUpperZ));
    is_digit = (c >= ChZero) && (c <= ChNine);
    is_idch  = is_alpha || is_digit || (c == ChUscore);
    is_hex   = 1'b1;
    if (is_digit) begin
      hex_d = c[3:0];
    end else if ((c >= ChLowerA) && (c <= ChLowerF)) begin
      hex_d = 4'(c - ChLowerA + 8'd10);
    end else if ((c >= ChUpperA) && (c <= ChUpperF)) begin
      hex_d = 4'(c - ChUpperA + 8'd10);
    end else begin
      hex_d  = '0;
      is_hex = 1'b0;
    end
  end

  assign reg_hit = reg_match(buf_q[23:0]);

  // Token output: close the running token if this byte ends it, then decode the byte afresh.
  always_comb begin
    end_v     = 1'b0;
    end_tok   = make_simple(TK_NUMBER);
    run_idle  = 1'b0;
    simp_v    = 1'b0;
    simp_kind = TK_EOF;

    unique case (mode_q)
      MODE_IDENT: begin
        if (!is_idch) begin
          end_v         = 1'b1;
          end_tok.text  = buf_q & LexMask;
          end_tok.len   = cnt_q;
          end_tok.trunc = (cnt_q > 6'(LexemeBytes));
          if ((cnt_q == 6'd3) && reg_hit[3]) begin
            end_tok.kind    = TK_REGISTER;
            end_tok.reg_idx = reg_hit[2:0];
          end else begin
            end_tok.kind = TK_IDENT;
          end
          run_idle = 1'b1;
        end
      end
      MODE_ZERO: begin
        if ((c != ChLowerX) && (c != ChUpperX)) begin
          end_v    = 1'b1;
          run_idle = 1'b1;
        end
      end
      MODE_HEX: begin
        if (!is_hex) begin
          end_v       = 1'b1;
          end_tok.num = 32'(acc_q);
          run_idle    = 1'b1;
        end
      end
      MODE_DEC: begin
        if (!is_digit) begin
          end_v       = 1'b1;
          end_tok.num = 32'(acc_q);
          run_idle    = 1'b1;
        end
      end
      MODE_STRING: begin
        if ((c == ChQuote) || (c == ChNul)) begin
          end_v         = 1'b1;
          end_tok.text  = buf_q & LexMask;
          end_tok.len   = cnt_q;
          end_tok.trunc = (cnt_q > 6'(LexemeBytes));
          if (cnt_q == 6'd1) begin
            end_tok.kind = TK_NUMBER;
            end_tok.num  = 32'(buf_q[7:0]);
          end else begin
            end_tok.kind = TK_STRING;
          end
          run_idle = (c == ChNul);
        end
      end
      MODE_COMMENT: begin
        run_idle = (c == ChLf) || (c == ChNul);
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    // Delimiters scanned from the idle mode give a plain token.
    if (run_idle) begin
      unique case (c)
        ChNul:   begin simp_v = 1'b1; simp_kind = TK_EOF;      end
        ChLf:    begin simp_v = 1'b1; simp_kind = TK_NEWLINE;  end
        ChComma: begin simp_v = 1'b1; simp_kind = TK_COMMA;    end
        ChColon: begin simp_v = 1'b1; simp_kind = TK_COLON;    end
        ChLbrk:  begin simp_v = 1'b1; simp_kind = TK_LBRACKET; end
        ChRbrk:  begin simp_v = 1'b1; simp_kind = TK_RBRACKET; end
        ChPlus:  begin simp_v = 1'b1; simp_kind = TK_PLUS;     end
        ChMinus: begin simp_v = 1'b1; simp_kind = TK_MINUS;    end
        default: ;
      endcase
    end
  end

  // Next scan mode and scan data.
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    buf_d  = buf_q;
    cnt_d  = cnt_q;

    unique case (mode_q)
      MODE_IDENT: begin
        if (is_idch) begin
          if (cnt_q < 6'd8) begin
            buf_d[{cnt_q[2:0], 3'b000} +: 8] = c;
          end
          if (cnt_q != 6'd63) begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      MODE_ZERO: begin
        if ((c == ChLowerX) || (c == ChUpperX)) begin
          acc_d  = '0;
          mode_d = MODE_HEX;
        end
      end
      MODE_HEX: begin
        if (is_hex) begin
          acc_d = {acc_q[NumberBits-5:0], hex_d};
        end
      end
      MODE_DEC: begin
        if (is_digit) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + NumberBits'(c[3:0]);
        end
      end
      MODE_STRING: begin
        if ((c == ChQuote) || (c == ChNul)) begin
          mode_d = MODE_IDLE;
        end else begin
          if (cnt_q < 6'd8) begin
            buf_d[{cnt_q[2:0], 3'b000} +: 8] = c;
          end
          if (cnt_q != 6'd63) begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      default: ;
    endcase

    // Fresh scan of the byte from the idle mode.
    if (run_idle) begin
      mode_d = MODE_IDLE;
      case (c)
        ChSemi:  mode_d = MODE_COMMENT;
        ChQuote: begin
          buf_d  = '0;
          cnt_d  = '0;
          mode_d = MODE_STRING;
        end
        default: begin
          if (is_alpha || (c == ChUscore)) begin
            buf_d  = {56'd0, c};
            cnt_d  = 6'd1;
            mode_d = MODE_IDENT;
          end else if (c == ChZero) begin
            acc_d  = '0;
            mode_d = MODE_ZERO;
          end else if (is_digit) begin
            acc_d  = NumberBits'(c[3:0]);
            mode_d = MODE_DEC;
          end
        end
      endcase
    end
  end

  // Record for the queue.
  always_comb begin
    if (end_v) begin
      rec_o.first = end_tok;
      rec_o.two   = simp_v;
    end else begin
      rec_o.first = make_simple(simp_kind);
      rec_o.two   = 1'b0;
    end
    rec_o.second = simp_kind;
  end

  assign push_o = fire && (end_v || simp_v);

  // Scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      buf_q  <= '0;
      cnt_q  <= '0;
    end else if (fire) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- rtl/ats_queue.sv -----
// Short record queue between the scanning front and the token output back.
`timescale 1ns / 1ps

module ats_queue import ats_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rec_t      rec_i,
  input  logic      pop_i,
  output rec_t      rec_o,
  output q_status_t stat_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  rec_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign rec_o        = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/ats_back.sv -----
// Back part: splits records into single tokens and holds them in the output register.
`timescale 1ns / 1ps

module ats_back import ats_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rec_t      rec_i,
  input  q_status_t q_stat_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tok_t      out_tok_o,
  output logic      out_last_o
);

  logic  valid_q, valid_d;
  logic  pend_q, pend_d;
  kind_e pend_kind_q;
  tok_t  tok_q, tok_d;
  logic  last_q, last_d;
  logic  load;

  assign load = !valid_q || out_ready_i;

  // Choose the next token: a pending second token first, else the queue head.
  always_comb begin
    pop_o   = 1'b0;
    valid_d = valid_q;
    pend_d  = pend_q;
    tok_d   = tok_q;
    last_d  = last_q;
    if (load) begin
      if (pend_q) begin
        valid_d = 1'b1;
        tok_d   = make_simple(pend_kind_q);
        last_d  = 1'b1;
        pend_d  = 1'b0;
      end else if (!q_stat_i.empty) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        tok_d   = rec_i.first;
        last_d  = !rec_i.two;
        pend_d  = rec_i.two;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    last_q <= last_d;
    if (pop_o) begin
      pend_kind_q <= rec_i.second;
    end
  end

  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;
  assign out_last_o  = last_q;

endmodule

// ----- rtl/assembler_token_scanner_top.sv -----
// Top level of the assembler token scanner: front, record queue and output stage.
// The first token of a byte passes through the record queue and then the output register.
// A byte that ends a token with a delimiter gives a second token once the first is taken.
// Throughput: one byte per cycle in, one token per cycle out while the receiver is ready;
// the four-entry record queue absorbs two-token bytes and stalls input only when full.
// Reset: asynchronous, active low; the scanner returns to idle with an empty queue.
`timescale 1ns / 1ps

module assembler_token_scanner_top import ats_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] character
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // [31:0] number_value, [34:32] register_index,
                                       // [98:35] lexeme_text, [104:99] lexeme_length,
                                       // [105] lexeme_truncated, [111:106] zero
  output logic [3:0]   m_axis_tuser,   // [3:0] token_kind
  output logic         m_axis_tlast    // last_of_run
);

  q_status_t q_stat;
  logic      q_push, q_pop;
  rec_t      push_rec, head_rec;
  tok_t      out_tok;

  // Byte scanning.
  ats_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .rec_o      (push_rec)
  );

  // Record queue.
  ats_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .rec_i  (push_rec),
    .pop_i  (q_pop),
    .rec_o  (head_rec),
    .stat_o (q_stat)
  );

  // Token output.
  ats_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (head_rec),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tok_o   (out_tok),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_tok.trunc, out_tok.len, out_tok.text,
                         out_tok.reg_idx, out_tok.num};
  assign m_axis_tuser = out_tok.kind;

  // A full queue never takes a record.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("record pushed into a full queue");

  // The output side never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty)
    else $error("record popped from an empty queue");

  // End of text is always the final token of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == TK_EOF)) |-> m_axis_tlast)
    else $error("end-of-text token not marked last");

  // A token followed by another of the same byte is one that the byte closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |->
      ((m_axis_tuser == TK_IDENT) || (m_axis_tuser == TK_REGISTER) ||
       (m_axis_tuser == TK_NUMBER) || (m_axis_tuser == TK_STRING)))
    else $error("delimiter token followed by a second token");

endmodule

// ----- dv/tb_assembler_token_scanner_top.sv -----
// Self-checking testbench for the assembler token scanner top level.
`timescale 1ns / 1ps

module tb_assembler_token_scanner_top;
  import ats_pkg::*;

  localparam int HalfPeriod    = 4;
  localparam int ResetCycles   = 9;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 16;

  // Kinds of source fragment the stimulus is built from.
  typedef enum int {
    U_IDENT, U_REGISTER, U_DECIMAL, U_HEX, U_ZERO_LEAD, U_STRING,
    U_COMMENT, U_DELIM, U_BLANK, U_NUL, U_NOISE
  } unit_e;

  // Mixes of fragments used by the random tests.
  typedef enum int { P_WORDS, P_NUMBERS, P_TEXT, P_MIXED, P_NOISY } profile_e;

  // One token as the scanner should deliver it.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] num;
    logic [2:0]  reg_idx;
    logic [63:0] text;
    logic [5:0]  len;
    logic        trunc;
    logic        last;
  } token_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // Scanner state mirrored by the token predictor.
  mode_e       scan_state = MODE_IDLE;
  logic [31:0] number_acc = '0;
  logic [63:0] lexeme_buf = '0;
  int unsigned lexeme_count = 0;

  token_t     step_tokens[$];
  token_t     expected_tokens[$];
  logic [7:0] source_text[$];

  string register_names[8] = '{"eax", "ebx", "ecx", "edx", "esi", "edi", "esp", "ebp"};

  int mismatches   = 0;
  int quiet_cycles = 0;
  bit sender_gaps    = 1'b1;
  bit receiver_stall = 1'b1;
  bit hold_request   = 1'b0;

  assembler_token_scanner_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_letter(logic [7:0] c);
    return (c >= ChLowerA && c <= ChLowerZ) || (c >= ChUpperA && c <= ChUpperZ);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic void add_token(kind_e kind, logic [31:0] num, logic [2:0] reg_idx,
                                    bit with_lexeme);
    token_t t;
    t.kind    = kind;
    t.num     = num;
    t.reg_idx = reg_idx;
    t.text    = with_lexeme ? lexeme_buf : '0;
    t.len     = with_lexeme ? 6'(lexeme_count) : '0;
    t.trunc   = with_lexeme && (lexeme_count > LexemeBytes);
    t.last    = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void clear_lexeme();
    lexeme_buf   = '0;
    lexeme_count = 0;
  endfunction

  // Only the first eight bytes are kept; the count saturates at 63.
  function automatic void append_lexeme(logic [7:0] c);
    if (lexeme_count < 8) lexeme_buf[8 * lexeme_count +: 8] = c;
    if (lexeme_count < 63) lexeme_count++;
  endfunction

  // A finished word is a register only when it is exactly one of the eight names.
  function automatic void finish_word();
    for (int r = 0; r < 8; r++) begin
      if (lexeme_count == 3 && lexeme_buf[7:0] == register_names[r][0] &&
          lexeme_buf[15:8] == register_names[r][1] &&
          lexeme_buf[23:16] == register_names[r][2]) begin
        add_token(TK_REGISTER, '0, 3'(r), 1'b1);
        return;
      end
    end
    add_token(TK_IDENT, '0, '0, 1'b1);
  endfunction

  // Scans a byte as though no token were under way.
  function automatic void scan_fresh(logic [7:0] c);
    scan_state = MODE_IDLE;
    case (c)
      ChSpace, ChTab, ChCr: ;
      ChNul:   add_token(TK_EOF, '0, '0, 1'b0);
      ChLf:    add_token(TK_NEWLINE, '0, '0, 1'b0);
      ChComma: add_token(TK_COMMA, '0, '0, 1'b0);
      ChColon: add_token(TK_COLON, '0, '0, 1'b0);
      ChLbrk:  add_token(TK_LBRACKET, '0, '0, 1'b0);
      ChRbrk:  add_token(TK_RBRACKET, '0, '0, 1'b0);
      ChPlus:  add_token(TK_PLUS, '0, '0, 1'b0);
      ChMinus: add_token(TK_MINUS, '0, '0, 1'b0);
      ChSemi:  scan_state = MODE_COMMENT;
      ChQuote: begin
        clear_lexeme();
        scan_state = MODE_STRING;
      end
      default: begin
        if (is_letter(c) || c == ChUscore) begin
          clear_lexeme();
          append_lexeme(c);
          scan_state = MODE_IDENT;
        end else if (c == ChZero) begin
          number_acc = '0;
          scan_state = MODE_ZERO;
        end else if (is_digit(c)) begin
          number_acc = 32'(c - ChZero);
          scan_state = MODE_DEC;
        end
      end
    endcase
  endfunction

  // Works out the tokens that one accepted byte causes and queues them.
  function automatic void predict_tokens(logic [7:0] c);
    int nibble;
    step_tokens.delete();
    case (scan_state)
      MODE_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == ChUscore) begin
          append_lexeme(c);
        end else begin
          finish_word();
          scan_fresh(c);
        end
      end
      MODE_ZERO: begin
        if (c == ChLowerX || c == ChUpperX) begin
          number_acc = '0;
          scan_state = MODE_HEX;
        end else begin
          add_token(TK_NUMBER, '0, '0, 1'b0);
          scan_fresh(c);
        end
      end
      MODE_HEX: begin
        if (is_digit(c)) nibble = c - ChZero;
        else if (c >= ChLowerA && c <= ChLowerF) nibble = c - ChLowerA + 10;
        else if (c >= ChUpperA && c <= ChUpperF) nibble = c - ChUpperA + 10;
        else nibble = 16;
        if (nibble < 16) begin
          number_acc = number_acc * 32'd16 + 32'(nibble);
        end else begin
          add_token(TK_NUMBER, number_acc, '0, 1'b0);
          scan_fresh(c);
        end
      end
      MODE_DEC: begin
        if (is_digit(c)) begin
          number_acc = number_acc * 32'd10 + 32'(c - ChZero);
        end else begin
          add_token(TK_NUMBER, number_acc, '0, 1'b0);
          scan_fresh(c);
        end
      end
      MODE_STRING: begin
        if (c == ChQuote || c == ChNul) begin
          // A one-character string stands for the value of that character.
          if (lexeme_count == 1) add_token(TK_NUMBER, 32'(lexeme_buf[7:0]), '0, 1'b1);
          else add_token(TK_STRING, '0, '0, 1'b1);
          scan_state = MODE_IDLE;
          if (c == ChNul) scan_fresh(c);
        end else begin
          append_lexeme(c);
        end
      end
      MODE_COMMENT: begin
        if (c == ChLf || c == ChNul) scan_fresh(c);
      end
      default: scan_fresh(c);
    endcase
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Source text generation
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? ChLowerA + 8'(r) : ChUpperA + 8'(r - 26);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return rand_letter();
    if (r < 62) return ChZero + 8'(r - 52);
    return ChUscore;
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return ChZero + 8'(r);
    if (r < 16) return ChLowerA + 8'(r - 10);
    return ChUpperA + 8'(r - 16);
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0: return ChTab;
      1: return ChCr;
      default: return ChSpace;
    endcase
  endfunction

  function automatic logic [7:0] rand_delimiter();
    case ($urandom_range(0, 6))
      0: return ChComma;
      1: return ChColon;
      2: return ChLbrk;
      3: return ChRbrk;
      4: return ChPlus;
      5: return ChMinus;
      default: return ChLf;
    endcase
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) source_text.push_back(s[i]);
  endfunction

  function automatic unit_e pick_unit(profile_e profile);
    int r;
    r = $urandom_range(0, 99);
    case (profile)
      P_WORDS:   return r < 45 ? U_IDENT : r < 80 ? U_REGISTER : r < 93 ? U_DELIM : U_NUL;
      P_NUMBERS: return r < 35 ? U_DECIMAL : r < 65 ? U_HEX : r < 80 ? U_ZERO_LEAD :
                        r < 95 ? U_DELIM : U_NUL;
      P_TEXT:    return r < 45 ? U_STRING : r < 80 ? U_COMMENT : r < 93 ? U_IDENT : U_NUL;
      P_NOISY:   return r < 40 ? U_NOISE : unit_e'($urandom_range(U_IDENT, U_NUL));
      default:   return unit_e'($urandom_range(U_IDENT, U_NUL));
    endcase
  endfunction

  // Appends one fragment of assembler source to the text waiting to be sent.
  function automatic void add_unit(unit_e u);
    int n;
    int r;
    logic [7:0] ch;
    case (u)
      U_IDENT: begin
        // Mostly short words, now and then one long enough to saturate the count.
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
        source_text.push_back(($urandom_range(0, 9) == 0) ? ChUscore : rand_letter());
        repeat (n - 1) source_text.push_back(rand_word_char());
      end
      U_REGISTER: begin
        r = $urandom_range(0, 7);
        ch = register_names[r][0];
        // Occasionally a near miss: wrong case or an extra character.
        if ($urandom_range(0, 7) == 0) ch = ch - 8'h20;
        source_text.push_back(ch);
        source_text.push_back(register_names[r][1]);
        source_text.push_back(register_names[r][2]);
        if ($urandom_range(0, 7) == 0) source_text.push_back(rand_word_char());
      end
      U_DECIMAL: begin
        source_text.push_back(ChZero + 8'($urandom_range(1, 9)));
        repeat ($urandom_range(0, 11)) source_text.push_back(ChZero + 8'($urandom_range(0, 9)));
      end
      U_HEX: begin
        source_text.push_back(ChZero);
        source_text.push_back($urandom_range(0, 1) ? ChLowerX : ChUpperX);
        repeat ($urandom_range(0, 10)) source_text.push_back(rand_hex_digit());
      end
      U_ZERO_LEAD: begin
        source_text.push_back(ChZero);
        repeat ($urandom_range(0, 3)) source_text.push_back(ChZero + 8'($urandom_range(0, 9)));
      end
      U_STRING: begin
        n = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(0, 10);
        source_text.push_back(ChQuote);
        repeat (n) begin
          do ch = 8'($urandom_range(1, 255)); while (ch == ChQuote);
          source_text.push_back(ch);
        end
        source_text.push_back(($urandom_range(0, 7) == 0) ? ChNul : ChQuote);
      end
      U_COMMENT: begin
        source_text.push_back(ChSemi);
        repeat ($urandom_range(0, 12)) begin
          do ch = 8'($urandom_range(1, 255)); while (ch == ChLf);
          source_text.push_back(ch);
        end
        source_text.push_back(($urandom_range(0, 5) == 0) ? ChNul : ChLf);
      end
      U_DELIM: source_text.push_back(rand_delimiter());
      U_BLANK: source_text.push_back(rand_blank());
      U_NUL:   source_text.push_back(ChNul);
      default: repeat ($urandom_range(1, 4)) source_text.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  function automatic void write_source(int n_chars, profile_e profile);
    while (source_text.size() < n_chars) begin
      add_unit(pick_unit(profile));
      if ($urandom_range(0, 1)) source_text.push_back(rand_blank());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Offers one source byte, with an occasional gap before it, until it is taken.
  task automatic send_char(input logic [7:0] ch);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tokens(ch);
  endtask

  task automatic send_text();
    while (source_text.size() > 0) send_char(source_text.pop_front());
  endtask

  // Token consumer: ready spans, short stalls, and one long hold on request.
  initial begin : token_sink
    int held;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
      end else if (receiver_stall && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Token checker
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : token_check
    token_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: token kind mismatch, expected none, actual 0x%0h",
                 $time, m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        compare_field("token_kind", want.kind, m_axis_tuser);
        compare_field("number_value", want.num, m_axis_tdata[31:0]);
        compare_field("register_index", want.reg_idx, m_axis_tdata[34:32]);
        compare_field("lexeme_text", want.text, m_axis_tdata[98:35]);
        compare_field("lexeme_length", want.len, m_axis_tdata[104:99]);
        compare_field("lexeme_truncated", want.trunc, m_axis_tdata[105]);
        compare_field("padding", '0, m_axis_tdata[111:106]);
        compare_field("last_of_run", want.last, m_axis_tlast);
      end
    end
  end

  // Ends the run if neither side moves a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Leading zero, empty hex, character and string literals, repeated end of text,
  // a comment closed by a newline, an unterminated string, a high byte and delimiters.
  task automatic test_directed();
    queue_text("012 0x,'a''ab'");
    source_text.push_back(ChNul);
    source_text.push_back(ChNul);
    queue_text(";c\n'q");
    source_text.push_back(ChNul);
    source_text.push_back(8'hFF);
    queue_text("[esi]:+-");
    send_text();
  endtask

  task automatic test_words();
    write_source(300, P_WORDS);
    send_text();
  endtask

  task automatic test_numbers();
    write_source(300, P_NUMBERS);
    send_text();
  endtask

  task automatic test_strings_comments();
    write_source(280, P_TEXT);
    send_text();
  endtask

  task automatic test_noise();
    write_source(250, P_NOISY);
    send_text();
  endtask

  // The consumer holds off while bytes keep coming, so the record queue fills.
  task automatic test_backpressure();
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    write_source(200, P_MIXED);
    send_text();
    sender_gaps = 1'b1;
  endtask

  task automatic test_full_rate();
    sender_gaps    = 1'b0;
    receiver_stall = 1'b0;
    write_source(200, P_MIXED);
    send_text();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_words();
    test_numbers();
    test_strings_comments();
    test_noise();
    test_backpressure();
    test_full_rate();

    s_axis_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
